// ===== rtl/cipm_pkg.sv =====
// Shared types and constants of the CPU idle percentage monitor.
`default_nettype none

package cipm_pkg;

  localparam int unsigned CPU_W      = 3;
  localparam int unsigned TICK_W     = 64;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned N_COUNTERS = 8;
  localparam int unsigned ALU_W      = TICK_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(TICK_W);

  localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             carry;
  } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/cipm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module cipm_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cipm_alu.sv =====
// Shared adder and subtractor used for the uptime sum, the deltas and the divider.
`default_nettype none

module cipm_alu (
  input  wire logic [cipm_pkg::ALU_W-1:0] a_i,
  input  wire logic [cipm_pkg::ALU_W-1:0] b_i,
  input  wire cipm_pkg::alu_ctl_t         ctl_i,
  output cipm_pkg::alu_res_t              res_o
);

  logic [cipm_pkg::ALU_W:0] wide;

  always_comb begin
    unique case (ctl_i.op)
      cipm_pkg::ALU_ADD: wide = {1'b0, a_i} + {1'b0, b_i};
      cipm_pkg::ALU_SUB: wide = {1'b0, a_i} - {1'b0, b_i};
      default:           wide = '0;
    endcase
    // For a subtraction the carry is the borrow: set when a_i < b_i.
    res_o.value = wide[cipm_pkg::ALU_W-1:0];
    res_o.carry = wide[cipm_pkg::ALU_W];
  end

endmodule

`default_nettype wire

// ===== rtl/cpu_idle_percent_monitor.sv =====
// Top level of the CPU idle percentage monitor: sequencer, state store and result register.
`default_nettype none

// Each input item carries one CPU's eight cumulative tick counters. The block
// reports the idle and busy share of the interval since that CPU's previous
// sample, plus the highest busy share seen in the current sampling round. The
// item with is_last_cpu_i set closes the round; the running maximum restarts
// at zero afterwards.
// Both channels use valid and stall: an item moves on a rising edge where
// valid is high and stall is low. in_stall_o is low only while the sequencer
// is idle, so one item is worked on at a time.
// Steps of an accepted item, in order: 8 adder passes for the uptime sum, 4
// for the deltas and the times-100 step, a zero check, 64 divider passes and
// the final step, all through one 65-bit adder. When the interval, new uptime
// or old uptime is zero the divider is skipped.
// The result sits in an output register. A new item is taken while it waits;
// if the receiver still stalls when the next result is ready, the sequencer
// holds that result in its final step until the register frees up.
// Reset clears the per-CPU valid bits at once, so every CPU's first sample
// reads a previous uptime of zero and reports 100 percent idle. No clearing
// pass runs over the store.
module cpu_idle_percent_monitor #(
  parameter int unsigned CPU_COUNT = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [cipm_pkg::CPU_W-1:0]    cpu_index_i,
  input  wire logic [cipm_pkg::TICK_W-1:0]   user_ticks_i,
  input  wire logic [cipm_pkg::TICK_W-1:0]   nice_ticks_i,
  input  wire logic [cipm_pkg::TICK_W-1:0]   system_ticks_i,
  input  wire logic [cipm_pkg::TICK_W-1:0]   idle_ticks_i,
  input  wire logic [cipm_pkg::TICK_W-1:0]   iowait_ticks_i,
  input  wire logic [cipm_pkg::TICK_W-1:0]   irq_ticks_i,
  input  wire logic [cipm_pkg::TICK_W-1:0]   softirq_ticks_i,
  input  wire logic [cipm_pkg::TICK_W-1:0]   steal_ticks_i,
  input  wire logic                          is_last_cpu_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [cipm_pkg::CPU_W-1:0]    cpu_echo_o,
  output logic      [cipm_pkg::PCT_W-1:0]    idle_percent_o,
  output logic      [cipm_pkg::PCT_W-1:0]    busy_percent_o,
  output logic      [cipm_pkg::PCT_W-1:0]    max_busy_percent_o,
  output logic                               round_end_o
);

  localparam int unsigned SLOT_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int unsigned ENTRY_W = 2 * cipm_pkg::TICK_W;
  localparam int unsigned TW      = cipm_pkg::TICK_W;
  localparam int unsigned CW      = cipm_pkg::DIV_CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_SUB_UP,
    S_SUB_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_CHECK,
    S_DIV,
    S_FIN
  } state_e;

  state_e                         state_q, state_d;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic [CPU_COUNT-1:0]           seen_q, seen_d;
  logic [cipm_pkg::PCT_W-1:0]     run_max_q, run_max_d;

  // Datapath registers.
  logic [TW-1:0]                  tick_q [cipm_pkg::N_COUNTERS];
  logic [TW-1:0]                  tick_d [cipm_pkg::N_COUNTERS];
  logic [TW-1:0]                  acc_q, acc_d;
  logic [TW-1:0]                  idle_q, idle_d;
  logic [TW-1:0]                  interval_q, interval_d;
  logic [TW-1:0]                  work_q, work_d;
  logic [cipm_pkg::ALU_W-1:0]     rem_q, rem_d;
  logic [cipm_pkg::CPU_W-1:0]     cpu_q, cpu_d;
  logic                           last_q, last_d;
  logic [SLOT_W-1:0]              slot_q, slot_d;
  logic                           special_q, special_d;
  logic                           prev_seen_q, prev_seen_d;

  logic                           in_accept;
  logic                           out_accept;
  logic                           fin_go;
  logic [8:0]                     slot_red;
  logic [ENTRY_W-1:0]             ram_rd;
  logic [TW-1:0]                  old_up;
  logic [TW-1:0]                  old_idle;
  logic [cipm_pkg::ALU_W-1:0]     alu_a, alu_b;
  logic [cipm_pkg::ALU_W-1:0]     div_shift;
  cipm_pkg::alu_ctl_t             alu_ctl;
  cipm_pkg::alu_res_t             alu_res;
  logic [cipm_pkg::PCT_W-1:0]     idle_pct, busy_pct, max_new;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;
  assign fin_go     = (state_q == S_FIN) && (!out_valid_o || !out_stall_i);

  // The store slot is the CPU index modulo CPU_COUNT. The index is only three
  // bits, so a few conditional subtractions of the constant are enough.
  always_comb begin
    slot_red = {6'd0, cpu_index_i};
    for (int i = 0; i < 7; i++) begin
      if (slot_red >= 9'(CPU_COUNT)) begin
        slot_red = slot_red - 9'(CPU_COUNT);
      end
    end
    slot_d = slot_red[SLOT_W-1:0];
  end

  // Previous uptime and idle count of every CPU, upper half uptime.
  cipm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CPU_COUNT)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (fin_go),
    .wr_addr_i (slot_q),
    .wr_data_i ({acc_q, idle_q}),
    .rd_en_i   (in_accept),
    .rd_addr_i (slot_d),
    .rd_data_o (ram_rd)
  );

  // An entry never written since reset reads as zero.
  assign old_up   = prev_seen_q ? ram_rd[ENTRY_W-1:TW] : '0;
  assign old_idle = prev_seen_q ? ram_rd[TW-1:0] : '0;

  cipm_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .ctl_i (alu_ctl),
    .res_o (alu_res)
  );

  // Restoring division step: shift the next dividend bit into the remainder.
  assign div_shift = {rem_q[TW-1:0], work_q[TW-1]};

  // Result of the finished item. The quotient saturates at 100.
  always_comb begin
    if (special_q || (|work_q[TW-1:cipm_pkg::PCT_W]) ||
        (work_q[cipm_pkg::PCT_W-1:0] > cipm_pkg::FULL_PERCENT)) begin
      idle_pct = cipm_pkg::FULL_PERCENT;
    end else begin
      idle_pct = work_q[cipm_pkg::PCT_W-1:0];
    end
    busy_pct = cipm_pkg::FULL_PERCENT - idle_pct;
    max_new  = (busy_pct > run_max_q) ? busy_pct : run_max_q;
  end

  // Sequencer and operand selection for the shared adder.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    seen_d      = seen_q;
    run_max_d   = run_max_q;
    tick_d      = tick_q;
    acc_d       = acc_q;
    idle_d      = idle_q;
    interval_d  = interval_q;
    work_d      = work_q;
    rem_d       = rem_q;
    cpu_d       = cpu_q;
    last_d      = last_q;
    special_d   = special_q;
    prev_seen_d = prev_seen_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_ctl.op  = cipm_pkg::ALU_ADD;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          tick_d[0]   = user_ticks_i;
          tick_d[1]   = nice_ticks_i;
          tick_d[2]   = system_ticks_i;
          tick_d[3]   = idle_ticks_i;
          tick_d[4]   = iowait_ticks_i;
          tick_d[5]   = irq_ticks_i;
          tick_d[6]   = softirq_ticks_i;
          tick_d[7]   = steal_ticks_i;
          idle_d      = idle_ticks_i;
          cpu_d       = cpu_index_i;
          last_d      = is_last_cpu_i;
          prev_seen_d = seen_q[slot_d];
          acc_d       = '0;
          cnt_d       = '0;
          state_d     = S_SUM;
        end
      end
      S_SUM: begin
        // One counter a cycle enters the wrapping uptime sum.
        alu_a = {1'b0, acc_q};
        alu_b = {1'b0, tick_q[0]};
        acc_d = alu_res.value[TW-1:0];
        for (int i = 0; i < cipm_pkg::N_COUNTERS - 1; i++) begin
          tick_d[i] = tick_q[i+1];
        end
        tick_d[cipm_pkg::N_COUNTERS-1] = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(cipm_pkg::N_COUNTERS - 1)) begin
          state_d = S_SUB_UP;
        end
      end
      S_SUB_UP: begin
        alu_ctl.op = cipm_pkg::ALU_SUB;
        alu_a      = {1'b0, acc_q};
        alu_b      = {1'b0, old_up};
        interval_d = alu_res.value[TW-1:0];
        state_d    = S_SUB_IDLE;
      end
      S_SUB_IDLE: begin
        alu_ctl.op = cipm_pkg::ALU_SUB;
        alu_a      = {1'b0, idle_q};
        alu_b      = {1'b0, old_idle};
        work_d     = alu_res.value[TW-1:0];
        state_d    = S_MUL_A;
      end
      S_MUL_A: begin
        // Times 100 as x*64 + x*32 + x*4, modulo 2^64.
        alu_a   = {1'b0, work_q[TW-7:0], 6'd0};
        alu_b   = {1'b0, work_q[TW-6:0], 5'd0};
        rem_d   = {1'b0, alu_res.value[TW-1:0]};
        state_d = S_MUL_B;
      end
      S_MUL_B: begin
        alu_a   = {1'b0, rem_q[TW-1:0]};
        alu_b   = {1'b0, work_q[TW-3:0], 2'd0};
        work_d  = alu_res.value[TW-1:0];
        rem_d   = '0;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        special_d = (interval_q == '0) || (acc_q == '0) || (old_up == '0);
        cnt_d     = '0;
        if ((interval_q == '0) || (acc_q == '0) || (old_up == '0)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        alu_ctl.op = cipm_pkg::ALU_SUB;
        alu_a      = div_shift;
        alu_b      = {1'b0, interval_q};
        if (!alu_res.carry) begin
          rem_d  = alu_res.value;
          work_d = {work_q[TW-2:0], 1'b1};
        end else begin
          rem_d  = div_shift;
          work_d = {work_q[TW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(TW - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          seen_d[slot_q] = 1'b1;
          run_max_d      = last_q ? '0 : max_new;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      cnt_q              <= '0;
      seen_q             <= '0;
      run_max_q          <= '0;
      out_valid_o        <= 1'b0;
      cpu_echo_o         <= '0;
      idle_percent_o     <= '0;
      busy_percent_o     <= '0;
      max_busy_percent_o <= '0;
      round_end_o        <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      seen_q    <= seen_d;
      run_max_q <= run_max_d;
      if (fin_go) begin
        out_valid_o        <= 1'b1;
        cpu_echo_o         <= cpu_q;
        idle_percent_o     <= idle_pct;
        busy_percent_o     <= busy_pct;
        max_busy_percent_o <= max_new;
        round_end_o        <= last_q;
      end else if (out_accept) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    tick_q      <= tick_d;
    acc_q       <= acc_d;
    idle_q      <= idle_d;
    interval_q  <= interval_d;
    work_q      <= work_d;
    rem_q       <= rem_d;
    cpu_q       <= cpu_d;
    last_q      <= last_d;
    special_q   <= special_d;
    prev_seen_q <= prev_seen_d;
    if (in_accept) begin
      slot_q <= slot_d;
    end
  end

  // A shown result always splits 100 percent between idle and busy.
  a_pct_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((8'(idle_percent_o) + 8'(busy_percent_o)) == 8'(cipm_pkg::FULL_PERCENT)))
    else $error("idle and busy percentages do not add up to 100");

  // The round maximum includes the busy share of the item it is shown with.
  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (max_busy_percent_o >= busy_percent_o))
    else $error("running maximum below the current busy percentage");

  // The divider runs exactly one pass per quotient bit, then finishes.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == CW'(TW - 1)) |=> (state_q == S_FIN))
    else $error("divider did not finish after its last pass");

endmodule

`default_nettype wire

// ===== test/tb_cpu_idle_percent_monitor.sv =====
// Self-checking testbench of the CPU idle percentage monitor with its own share predictor.
`default_nettype none

module tb_cpu_idle_percent_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths and constants of the block, taken from its package.
  localparam int unsigned      CPU_W        = cipm_pkg::CPU_W;
  localparam int unsigned      TICK_W       = cipm_pkg::TICK_W;
  localparam int unsigned      PCT_W        = cipm_pkg::PCT_W;
  localparam int unsigned      N_COUNTERS   = cipm_pkg::N_COUNTERS;
  localparam logic [PCT_W-1:0] FULL_PERCENT = cipm_pkg::FULL_PERCENT;

  // The store has one entry per CPU; the index is reduced modulo this count.
  localparam int unsigned NUM_CPUS = 8;
  // Position of each counter inside a tick set, in port order.
  localparam int unsigned USER_SLOT    = 0;
  localparam int unsigned NICE_SLOT    = 1;
  localparam int unsigned SYSTEM_SLOT  = 2;
  localparam int unsigned IDLE_SLOT    = 3;
  localparam int unsigned IOWAIT_SLOT  = 4;
  localparam int unsigned IRQ_SLOT     = 5;
  localparam int unsigned SOFTIRQ_SLOT = 6;
  localparam int unsigned STEAL_SLOT   = 7;
  // Random items in each half of the random traffic.
  localparam int unsigned RANDOM_HALF  = 675;
  // Cycles to idle at the end.
  localparam int unsigned TAIL_CYCLES  = 100;

  typedef logic [N_COUNTERS-1:0][TICK_W-1:0] tick_set_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    tick_set_t        ticks;
    logic             last;
  } sample_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic [PCT_W-1:0] idle;
    logic [PCT_W-1:0] busy;
    logic [PCT_W-1:0] peak;
    logic             round_end;
  } share_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_LONG
  } stall_mode_e;

  typedef enum logic [1:0] {
    NOISE_RANDOM,
    NOISE_ZERO,
    NOISE_REPEAT,
    NOISE_BACKWARD
  } noise_kind_e;

  typedef enum logic [1:0] {
    DELTA_MIXED,
    DELTA_ALL_IDLE,
    DELTA_ALL_BUSY,
    DELTA_LARGE
  } delta_kind_e;

  // Every input is known from time zero; reset is held low from the start.
  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [CPU_W-1:0]      cpu_index        = '0;
  logic [TICK_W-1:0]     user_ticks       = '0;
  logic [TICK_W-1:0]     nice_ticks       = '0;
  logic [TICK_W-1:0]     system_ticks     = '0;
  logic [TICK_W-1:0]     idle_ticks       = '0;
  logic [TICK_W-1:0]     iowait_ticks     = '0;
  logic [TICK_W-1:0]     irq_ticks        = '0;
  logic [TICK_W-1:0]     softirq_ticks    = '0;
  logic [TICK_W-1:0]     steal_ticks      = '0;
  logic                  is_last_cpu      = 1'b0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [CPU_W-1:0]      cpu_echo;
  logic [PCT_W-1:0]      idle_percent;
  logic [PCT_W-1:0]      busy_percent;
  logic [PCT_W-1:0]      max_busy_percent;
  logic                  round_end;

  // Predictor state: a private copy of the per-CPU store and the round peak.
  logic [TICK_W-1:0]     prior_uptime [NUM_CPUS];
  logic [TICK_W-1:0]     prior_idle   [NUM_CPUS];
  logic [PCT_W-1:0]      round_peak   = '0;

  // Shares predicted for accepted items, oldest first.
  share_t                pending_shares [$];
  int unsigned           error_count  = 0;

  // Stimulus side: the counters last sent for each CPU, so that well-formed
  // rounds keep counting up from where the block's store stands.
  tick_set_t             sent_counters [NUM_CPUS];

  // Sender pacing: bursts of back-to-back items separated by random gaps.
  int unsigned           burst_left   = 0;

  // Receiver stall pattern.
  stall_mode_e           stall_mode   = STALL_NONE;
  int unsigned           segment_left = 0;
  int unsigned           hold_left    = 0;

  cpu_idle_percent_monitor #(
    .CPU_COUNT(NUM_CPUS)
  ) u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .cpu_index_i        (cpu_index),
    .user_ticks_i       (user_ticks),
    .nice_ticks_i       (nice_ticks),
    .system_ticks_i     (system_ticks),
    .idle_ticks_i       (idle_ticks),
    .iowait_ticks_i     (iowait_ticks),
    .irq_ticks_i        (irq_ticks),
    .softirq_ticks_i    (softirq_ticks),
    .steal_ticks_i      (steal_ticks),
    .is_last_cpu_i      (is_last_cpu),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .cpu_echo_o         (cpu_echo),
    .idle_percent_o     (idle_percent),
    .busy_percent_o     (busy_percent),
    .max_busy_percent_o (max_busy_percent),
    .round_end_o        (round_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one accepted item and advances the predictor
  // state. Uptime and both deltas wrap modulo 2^64, and so does the product
  // of the idle delta with one hundred before the division.
  function automatic share_t compute_share(input sample_t s);
    logic [TICK_W-1:0] uptime;
    logic [TICK_W-1:0] interval;
    logic [TICK_W-1:0] idle_delta;
    logic [TICK_W-1:0] quotient;
    int unsigned       entry;
    int unsigned       i;
    share_t            r;
    entry = s.cpu % NUM_CPUS;
    uptime = '0;
    for (i = 0; i < N_COUNTERS; i++) begin
      uptime = uptime + s.ticks[i];
    end
    interval = uptime - prior_uptime[entry];
    idle_delta = s.ticks[IDLE_SLOT] - prior_idle[entry];
    // A CPU seen for the first time, an all-zero sample and an empty
    // interval all count as fully idle.
    if (interval == '0 || uptime == '0 || prior_uptime[entry] == '0) begin
      quotient = TICK_W'(FULL_PERCENT);
    end else begin
      quotient = (idle_delta * 64'd100) / interval;
      if (quotient > TICK_W'(FULL_PERCENT)) begin
        quotient = TICK_W'(FULL_PERCENT);
      end
    end
    r.cpu = s.cpu;
    r.idle = quotient[PCT_W-1:0];
    r.busy = FULL_PERCENT - r.idle;
    if (r.busy > round_peak) begin
      round_peak = r.busy;
    end
    r.peak = round_peak;
    r.round_end = s.last;
    prior_uptime[entry] = uptime;
    prior_idle[entry] = s.ticks[IDLE_SLOT];
    // The closing item still reports the peak that includes it.
    if (s.last) begin
      round_peak = '0;
    end
    return r;
  endfunction

  function automatic logic [TICK_W-1:0] rand_ticks();
    return {$urandom, $urandom};
  endfunction

  // A tick set with every busy counter at busy_each and the idle counter at idle.
  function automatic tick_set_t split_ticks(input logic [TICK_W-1:0] busy_each,
                                            input logic [TICK_W-1:0] idle);
    tick_set_t t;
    int unsigned i;
    for (i = 0; i < N_COUNTERS; i++) begin
      t[i] = busy_each;
    end
    t[IDLE_SLOT] = idle;
    return t;
  endfunction

  // Sends one item: the payload and valid are set at the current edge and
  // held until an edge where the block does not stall. The expectation is
  // queued at the accepting edge, then the sender may pause before the next
  // item. Valid is lowered only when a real gap follows.
  task automatic send_sample(input logic [CPU_W-1:0] cpu, input tick_set_t ticks,
                             input logic last);
    sample_t     s;
    int unsigned gap;
    s.cpu = cpu;
    s.ticks = ticks;
    s.last = last;
    cpu_index     <= cpu;
    user_ticks    <= ticks[USER_SLOT];
    nice_ticks    <= ticks[NICE_SLOT];
    system_ticks  <= ticks[SYSTEM_SLOT];
    idle_ticks    <= ticks[IDLE_SLOT];
    iowait_ticks  <= ticks[IOWAIT_SLOT];
    irq_ticks     <= ticks[IRQ_SLOT];
    softirq_ticks <= ticks[SOFTIRQ_SLOT];
    steal_ticks   <= ticks[STEAL_SLOT];
    is_last_cpu   <= last;
    in_valid      <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_shares.push_back(compute_share(s));
    sent_counters[cpu % NUM_CPUS] = ticks;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      // Short gaps most of the time, and now and then a long one so that
      // gaps land on every step of the sequencer.
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 90);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Holds the sender off until every predicted share has been checked.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_shares.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Every CPU's first sample after reset reports fully idle; the round
  // closes on the eighth CPU.
  task automatic test_first_samples();
    int unsigned c;
    for (c = 0; c < NUM_CPUS; c++) begin
      send_sample(CPU_W'(c), split_ticks(64'(100 * (c + 1)), 64'd50), c == NUM_CPUS - 1);
    end
  endtask

  // An unchanged sample gives an empty interval, an all-zero sample gives a
  // zero uptime and the sample after it sees a zero old uptime. All-ones
  // counters make the uptime sum wrap.
  task automatic test_degenerate_intervals();
    send_sample(CPU_W'(0), split_ticks(64'd100, 64'd50), 1'b0);
    send_sample(CPU_W'(1), '0, 1'b0);
    send_sample(CPU_W'(1), split_ticks(64'd10, 64'd10), 1'b0);
    send_sample(CPU_W'(2), '1, 1'b1);
  endtask

  // Exactly full idle, fully busy, an even split, idle growing faster than
  // the interval (counters running backwards) and an idle delta whose
  // product with one hundred wraps to zero. Then an item with every bit set.
  task automatic test_percent_extremes();
    send_sample(CPU_W'(3), split_ticks(64'd400, 64'd150), 1'b0);
    send_sample(CPU_W'(4), split_ticks(64'd600, 64'd50), 1'b0);
    send_sample(CPU_W'(5), split_ticks(64'd601, 64'd57), 1'b0);
    send_sample(CPU_W'(6), split_ticks(64'd699, 64'd1050), 1'b0);
    send_sample(CPU_W'(7), split_ticks(64'd800, 64'd50 + (64'd1 << 62)), 1'b1);
    send_sample(CPU_W'(7), '1, 1'b1);
  endtask

  // The peak climbs and holds within a round and starts over after the
  // closing item.
  task automatic test_round_peak();
    send_sample(CPU_W'(0), split_ticks(64'd110, 64'd55), 1'b0);
    send_sample(CPU_W'(1), split_ticks(64'd20, 64'd20), 1'b0);
    send_sample(CPU_W'(2), split_ticks(64'd5, 64'd3), 1'b1);
    send_sample(CPU_W'(0), split_ticks(64'd111, 64'd62), 1'b1);
  endtask

  // Advances one CPU's counters as a real system would: each counter gains a
  // random amount, which may be zero, with the idle share anywhere from none to all of it.
  function automatic tick_set_t advance_counters(input tick_set_t prev);
    tick_set_t   t;
    delta_kind_e kind;
    int unsigned i;
    kind = delta_kind_e'($urandom_range(0, 3));
    for (i = 0; i < N_COUNTERS; i++) begin
      case (kind)
        DELTA_MIXED: begin
          t[i] = prev[i] + ((i == IDLE_SLOT) ? $urandom_range(0, 8000) : $urandom_range(0, 1000));
        end
        DELTA_ALL_IDLE: begin
          t[i] = prev[i] + ((i == IDLE_SLOT) ? $urandom_range(1, 1000) : 0);
        end
        DELTA_ALL_BUSY: begin
          t[i] = prev[i] + ((i == IDLE_SLOT) ? 0 : $urandom_range(1, 1000));
        end
        default: begin
          t[i] = prev[i] + {$urandom_range(0, 255), $urandom};
        end
      endcase
    end
    return t;
  endfunction

  // Mostly well-formed rounds over a random subset of CPUs in random order,
  // mixed with stray items: arbitrary counters, all zeros, repeats and
  // counters that run backwards, each with a random round marker.
  task automatic test_random_traffic(input int unsigned item_target);
    int unsigned      sent;
    int unsigned      count;
    int unsigned      k;
    int unsigned      j;
    logic [CPU_W-1:0] order [NUM_CPUS];
    logic [CPU_W-1:0] swap;
    logic [CPU_W-1:0] cpu;
    tick_set_t        t;
    noise_kind_e      kind;
    sent = 0;
    while (sent < item_target) begin
      if ($urandom_range(0, 99) < 85) begin
        for (k = 0; k < NUM_CPUS; k++) begin
          order[k] = CPU_W'(k);
        end
        for (k = NUM_CPUS - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          swap = order[k];
          order[k] = order[j];
          order[j] = swap;
        end
        count = $urandom_range(1, NUM_CPUS);
        for (k = 0; k < count; k++) begin
          send_sample(order[k], advance_counters(sent_counters[order[k]]), k == count - 1);
          sent++;
        end
      end else begin
        cpu = CPU_W'($urandom_range(0, NUM_CPUS - 1));
        kind = noise_kind_e'($urandom_range(0, 3));
        for (k = 0; k < N_COUNTERS; k++) begin
          case (kind)
            NOISE_RANDOM:   t[k] = rand_ticks();
            NOISE_ZERO:     t[k] = '0;
            NOISE_REPEAT:   t[k] = sent_counters[cpu][k];
            default:        t[k] = sent_counters[cpu][k] - $urandom_range(0, 500);
          endcase
        end
        send_sample(cpu, t, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned expected,
                             input int unsigned actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
      error_count++;
    end
  endtask

  // Result side: each result taken at an edge where valid is high and the
  // stall is low is compared with the oldest prediction. The stall pattern
  // switches between no stalls, random stalls and long holds.
  always @(posedge clk) begin
    share_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_shares.size() == 0) begin
        $display("%0t: result with no item pending: cpu_echo %0d, idle_percent %0d",
                 $time, cpu_echo, idle_percent);
        error_count++;
      end else begin
        want = pending_shares.pop_front();
        check_field("cpu_echo", want.cpu, cpu_echo);
        check_field("idle_percent", want.idle, idle_percent);
        check_field("busy_percent", want.busy, busy_percent);
        check_field("max_busy_percent", want.peak, max_busy_percent);
        check_field("round_end", want.round_end, round_end);
      end
    end
    if (segment_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      segment_left <= $urandom_range(50, 400);
    end else begin
      segment_left <= segment_left - 1;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 99) < 40);
      end
      default: begin
        if (hold_left == 0) begin
          out_stall <= ~out_stall;
          hold_left <= $urandom_range(1, 100);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // Main sequence: reset once, the directed checks, then random traffic in
  // two halves with a full drain of the block between them.
  initial begin
    int unsigned c;
    for (c = 0; c < NUM_CPUS; c++) begin
      prior_uptime[c] = '0;
      prior_idle[c] = '0;
      sent_counters[c] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_samples();
    test_degenerate_intervals();
    test_percent_extremes();
    test_round_peak();
    test_random_traffic(RANDOM_HALF);
    wait_all_results();
    test_random_traffic(RANDOM_HALF);
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: ends the run with a failure if the main sequence does not finish.
  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== cpu_idle_percent_monitor.f =====
rtl/cipm_pkg.sv
rtl/cipm_ram.sv
rtl/cipm_alu.sv
rtl/cpu_idle_percent_monitor.sv
test/tb_cpu_idle_percent_monitor.sv
